[rtl/hmvp_pkg.sv]
`default_nettype none
package hmvp_pkg;

	localparam int unsigned POS_W       = 32;
	localparam int unsigned PROB_W      = 16;
	localparam int unsigned CTX_W       = 6;
	localparam int unsigned CONF_W      = 16;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CONF_STATES = 32;
	localparam int unsigned CS_W        = 5;

	localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;
	localparam logic [63:0] MIX_MUL    = 64'hff51afd7ed558ccd;

	localparam logic [15:0] LEARN_RATE_RST = 16'd655;
	localparam logic [15:0] CONF_FLOOR_RST = 16'd655;
	localparam logic [15:0] CONF_CEIL_RST  = 16'd64881;
	localparam logic [15:0] CONF_INIT      = 16'd32768;
	localparam logic [15:0] PROB_HALF      = 16'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEARN_RATE   = 2'd0,
		CFG_CONF_FLOOR   = 2'd1,
		CFG_CONF_CEILING = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_ADP, ST_ADP_W, ST_SHIFT, ST_HASH, ST_HASH_W, ST_MIX, ST_MIX_W,
		ST_BRD, ST_BCHK, ST_WAY, ST_NRD, ST_NWT, ST_MRD, ST_MCMP, ST_VOTE, ST_SEL, ST_DEC,
		ST_BWR, ST_PINC, ST_PRED
	} hmvp_state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic agree;
		logic want;
	} pred_t;

	// Number of bits already gathered in the current byte, capped at seven.
	function automatic logic [2:0] bits_seen(input logic [8:0] p);
		logic [2:0] n;
		n = '0;
		for (int i = 1; i < 9; i++) begin
			if (p[i]) begin
				n = (i > 7) ? 3'd7 : 3'(i);
			end
		end
		return n;
	endfunction

	// Whether the gathered bits agree with the expected byte, and the bit expected next.
	function automatic pred_t pred_of(input logic [8:0] p, input logic [7:0] e);
		pred_t      r;
		logic [2:0] n;
		logic [7:0] mask;
		logic [7:0] top;
		n = bits_seen(p);
		mask = 8'((9'd1 << n) - 9'd1);
		top = e >> (4'd8 - {1'b0, n});
		r.agree = (p[7:0] & mask) == top;
		r.want = e[3'd7 - n];
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/hmvp_ifs.sv]
`default_nettype none
interface hmvp_bit_if;
	import hmvp_pkg::*;
	logic valid;
	logic ready;
	logic coded_bit;
	modport source (output valid, output coded_bit, input ready);
	modport sink (input valid, input coded_bit, output ready);
endinterface

interface hmvp_res_if;
	import hmvp_pkg::*;
	logic              valid;
	logic              ready;
	logic [PROB_W-1:0] prob_one;
	logic [CTX_W-1:0]  mixer_ctx;
	logic              byte_done;
	modport source (output valid, output prob_one, output mixer_ctx, output byte_done,
		input ready);
	modport sink (input valid, input prob_one, input mixer_ctx, input byte_done,
		output ready);
endinterface

interface hmvp_cfg_if;
	import hmvp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/hmvp_mul.sv]
`default_nettype none
// Low 64 bits of a 64 by 64 product, built from three 32 by 32 partial products
// on one shared multiplier.
module hmvp_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  hmvp_pkg::mul_req_t req,
	output hmvp_pkg::mul_rsp_t rsp
);
	import hmvp_pkg::*;

	logic [63:0] a_q, b_q, acc_q, pp_q, pp_next;
	logic [31:0] op_x, op_y;
	logic [1:0]  step_q;
	logic        busy_q, done_q;

	always_comb begin
		op_x = (step_q == 2'd1) ? a_q[63:32] : a_q[31:0];
		op_y = (step_q == 2'd2) ? b_q[63:32] : b_q[31:0];
		pp_next = op_x * op_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		if (busy_q) begin
			pp_q <= pp_next;
			case (step_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= pp_q;
				default: acc_q <= acc_q + {pp_q[31:0], 32'b0};
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule
`default_nettype wire

[rtl/hmvp_ram2.sv]
`default_nettype none
// History store: one write port, two registered read ports.
module hmvp_ram2 #(
	parameter int unsigned DW = 8,
	parameter int unsigned AW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [DW-1:0] wd,
	input  logic [AW-1:0] ra,
	input  logic [AW-1:0] rb,
	output logic [DW-1:0] rda,
	output logic [DW-1:0] rdb
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rda <= mem[ra];
		rdb <= mem[rb];
	end

endmodule
`default_nettype wire

[rtl/hmvp_ram1.sv]
`default_nettype none
// Bucket store: one write port, one registered read port.
module hmvp_ram1 #(
	parameter int unsigned DW = 64,
	parameter int unsigned AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [DW-1:0] wd,
	input  logic [AW-1:0] ra,
	output logic [DW-1:0] rd
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end

endmodule
`default_nettype wire

[rtl/hashed_match_vote_predictor_core.sv]
`default_nettype none
// Channel   Role    Payload                                Moves
// bits      sink    coded_bit                              one request per data bit
// results   source  prob_one, mixer_ctx, byte_done         one request per accepted bit
// cfg       sink    index, data                            at most one register write per request
//
// A bit that does not complete a byte is shifted in and predicted, after the confidence
// adapts through the shared multiplier where it does. A completing bit adds the eight hash
// steps and the final mix (each a pass of the shared 64-bit multiply sequence), the bucket
// read, check, write and the position step, a comparison of each candidate way over L
// bytes of the history store (L up to MAX_MATCH), a skip past each ineligible way, and
// the selection over the vote values.
// After reset the bucket store is swept clean while no bit is taken.
// A result waits in its output register; the next bit is taken while it waits.
module hashed_match_vote_predictor_core #(
	parameter int unsigned HISTORY_DEPTH = 65536,
	parameter int unsigned BUCKET_DEPTH  = 4096,
	parameter int unsigned WAY_COUNT     = 4,
	parameter int unsigned MAX_MATCH     = 64
) (
	input  logic clk,
	input  logic arst_n,
	hmvp_bit_if.sink   bits,
	hmvp_res_if.source results,
	hmvp_cfg_if.sink   cfg
);
	import hmvp_pkg::*;

	localparam int unsigned HA      = $clog2(HISTORY_DEPTH);
	localparam int unsigned BA      = $clog2(BUCKET_DEPTH);
	localparam int unsigned WI      = $clog2(WAY_COUNT + 1);
	localparam int unsigned IW      = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
	localparam int unsigned VW      = (WI > 2) ? WI : 2;
	localparam int unsigned JW      = $clog2(MAX_MATCH + 1);
	localparam int unsigned SW      = $clog2(WAY_COUNT * MAX_MATCH + 1);
	localparam int unsigned PW      = WAY_COUNT * POS_W;
	localparam int unsigned KEY_LSB = PW;
	localparam int unsigned VLD_LSB = PW + 64;
	localparam int unsigned RW      = VLD_LSB + WAY_COUNT;

	localparam logic [POS_W-1:0] HIST_SPAN = POS_W'(HISTORY_DEPTH);
	localparam logic [JW-1:0]    MIN_MATCH = JW'(8);
	localparam logic [JW-1:0]    MATCH_CAP = JW'(MAX_MATCH);
	localparam logic [WI-1:0]    WAYS      = WI'(WAY_COUNT);
	localparam logic [BA-1:0]    CLR_LAST  = BA'(BUCKET_DEPTH - 1);

	hmvp_state_t state_q, state_d;

	// Control state.
	logic [15:0]      learn_rate_q, conf_floor_q, conf_ceiling_q;
	logic [8:0]       partial_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       exp_q;
	logic [CS_W-1:0]  conf_state_q;
	logic             active_q;
	logic [15:0]      conf_tbl_q [CONF_STATES];
	logic [BA-1:0]    clr_idx_q;
	logic [2:0]       k_q;
	logic [WI-1:0]    wi_q, used_q, si_q;
	logic             out_valid_q;
	logic             tie_q;
	logic             match_q;

	// Data registers.
	logic              bit_q, done_q;
	logic [7:0]        win_q [8];
	logic [63:0]       h_q, key_q;
	logic [RW-1:0]     row_q;
	logic [POS_W-1:0]  cand_q;
	logic [7:0]        nxt_q;
	logic [JW-1:0]     j_q;
	logic [7:0]        val_q [WAY_COUNT];
	logic [SW-1:0]     score_q [WAY_COUNT];
	logic [VW-1:0]     votes_q [WAY_COUNT];
	logic [7:0]        best_val_q;
	logic [SW-1:0]     best_score_q;
	logic [VW-1:0]     best_votes_q;
	logic [PROB_W-1:0] prob_q;
	logic [CTX_W-1:0]  ctx_q;
	logic              bdone_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	logic          h_we;
	logic [HA-1:0] h_wa, h_ra, h_rb;
	logic [7:0]    h_wd, h_rda, h_rdb;
	logic          b_we;
	logic [BA-1:0] b_wa;
	logic [RW-1:0] b_wd, b_rd;

	hmvp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	hmvp_ram2 #(.DW(8), .AW(HA)) u_hist (
		.clk (clk),
		.we  (h_we),
		.wa  (h_wa),
		.wd  (h_wd),
		.ra  (h_ra),
		.rb  (h_rb),
		.rda (h_rda),
		.rdb (h_rdb)
	);

	hmvp_ram1 #(.DW(RW), .AW(BA)) u_bucket (
		.clk (clk),
		.we  (b_we),
		.wa  (b_wa),
		.wd  (b_wd),
		.ra  (key_q[BA-1:0]),
		.rd  (b_rd)
	);

	// Prediction view of the current partial byte. Before the shift it drives the
	// adaptation, after it the new prediction.
	pred_t        pv;
	logic [15:0]  conf_cur;
	logic [8:0]   shifted;
	logic         completes;
	logic         accept;
	logic [IW-1:0] way_idx;
	logic [POS_W-1:0] way_cand, cand_next, cand_back, pos_back, j_ext;
	logic         way_vld, elig, match_stop, key_eq;
	logic [33:0]  adp_sum;
	logic [17:0]  nc, nc_ceil, nc_floor;
	logic [15:0]  nc_sat, prob_next;
	logic [CTX_W-1:0] ctx_next;
	logic         hit_any;
	logic [IW-1:0] hit_idx;
	logic [SW-1:0] sel_score;
	logic [SW-1:0] lb_full;
	logic [VW-1:0] vb_full;
	logic [2:0]   lb;
	logic [1:0]   vb;
	logic [WAY_COUNT-1:0] new_vld;
	logic [PW-1:0] old_pos, new_pos;

	always_comb begin
		pv = pred_of(partial_q, exp_q);
		conf_cur = conf_tbl_q[conf_state_q];
		shifted = {partial_q[7:0], bit_q};
		completes = shifted[8];
		accept = bits.valid && (state_q == ST_IDLE);

		way_idx = wi_q[IW-1:0];
		way_cand = row_q[way_idx * POS_W +: POS_W];
		way_vld = row_q[VLD_LSB + way_idx];
		// A way votes only if its position leaves a following byte inside the ring.
		elig = way_vld && ((way_cand + 32'd1) < pos_q) && ((pos_q - way_cand) < HIST_SPAN);

		j_ext = POS_W'(j_q);
		cand_next = cand_q + 32'd1;
		cand_back = cand_q - j_ext;
		pos_back = pos_q - j_ext;
		match_stop = (j_q >= MIN_MATCH) &&
			((j_q >= MATCH_CAP) || (cand_q < j_ext) || (pos_q < j_ext));
		key_eq = b_rd[KEY_LSB +: 64] == key_q;

		// Confidence moves toward one on agreement and toward zero otherwise.
		adp_sum = mul_rsp.prod[33:0] + ((bit_q == pv.want) ? {2'b0, learn_rate_q, 16'b0} : 34'd0)
			+ 34'd32768;
		nc = adp_sum[33:16];
		nc_ceil = (nc > {2'b0, conf_ceiling_q}) ? {2'b0, conf_ceiling_q} : nc;
		nc_floor = (nc_ceil < {2'b0, conf_floor_q}) ? {2'b0, conf_floor_q} : nc_ceil;
		nc_sat = (nc_floor > 18'd65535) ? 16'hffff : nc_floor[15:0];

		prob_next = PROB_HALF;
		if (active_q && pv.agree) begin
			if (pv.want) begin
				prob_next = conf_cur;
			end else begin
				prob_next = (conf_cur == 16'd0) ? 16'hffff : 16'(17'h10000 - {1'b0, conf_cur});
			end
		end
		ctx_next = active_q ? (CTX_W'(conf_state_q) + 6'd1) : '0;

		hit_any = 1'b0;
		hit_idx = '0;
		for (int k = WAY_COUNT - 1; k >= 0; k--) begin
			if ((WI'(k) < used_q) && (val_q[k] == nxt_q)) begin
				hit_any = 1'b1;
				hit_idx = IW'(k);
			end
		end
		sel_score = score_q[si_q[IW-1:0]];

		lb_full = best_score_q >> 4;
		lb = (lb_full > SW'(7)) ? 3'd7 : lb_full[2:0];
		vb_full = best_votes_q - VW'(1);
		vb = (vb_full > VW'(3)) ? 2'd3 : vb_full[1:0];

		// New entry goes to way 0; a fresh key drops all older ways.
		new_vld = (match_q ? (row_q[VLD_LSB +: WAY_COUNT] << 1) : '0) | WAY_COUNT'(1);
		old_pos = match_q ? row_q[PW-1:0] : '0;
		new_pos = (old_pos << POS_W) | PW'(pos_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:    if (clr_idx_q == CLR_LAST) state_d = ST_IDLE;
			ST_IDLE:   if (accept) state_d = (active_q && pv.agree) ? ST_ADP : ST_SHIFT;
			ST_ADP:    state_d = ST_ADP_W;
			ST_ADP_W:  if (mul_rsp.done) state_d = ST_SHIFT;
			ST_SHIFT: begin
				if (!completes) state_d = ST_PRED;
				else state_d = (pos_q >= 32'd7) ? ST_HASH : ST_PINC;
			end
			ST_HASH:   state_d = ST_HASH_W;
			ST_HASH_W: if (mul_rsp.done) state_d = (k_q == 3'd0) ? ST_MIX : ST_HASH;
			ST_MIX:    state_d = ST_MIX_W;
			ST_MIX_W:  if (mul_rsp.done) state_d = ST_BRD;
			ST_BRD:    state_d = ST_BCHK;
			ST_BCHK:   state_d = key_eq ? ST_WAY : ST_BWR;
			ST_WAY: begin
				if (wi_q == WAYS) state_d = ST_SEL;
				else if (elig) state_d = ST_NRD;
			end
			ST_NRD:    state_d = ST_NWT;
			ST_NWT:    state_d = ST_MRD;
			ST_MRD:    state_d = match_stop ? ST_VOTE : ST_MCMP;
			ST_MCMP: begin
				if (h_rda != h_rdb) state_d = (j_q < MIN_MATCH) ? ST_WAY : ST_VOTE;
				else state_d = ST_MRD;
			end
			ST_VOTE:   state_d = ST_WAY;
			ST_SEL:    if (si_q == used_q) state_d = ST_DEC;
			ST_DEC:    state_d = ST_BWR;
			ST_BWR:    state_d = ST_PINC;
			ST_PINC:   state_d = ST_PRED;
			ST_PRED:   if (!out_valid_q || results.ready) state_d = ST_IDLE;
			default:   state_d = ST_CLR;
		endcase
	end

	// Outputs toward the ports, the shared multiplier and the stores.
	always_comb begin
		bits.ready = (state_q == ST_IDLE);
		cfg.ready = 1'b1;
		results.valid = out_valid_q;
		results.prob_one = prob_q;
		results.mixer_ctx = ctx_q;
		results.byte_done = bdone_q;

		mul_req.start = 1'b0;
		mul_req.a = {48'b0, conf_cur};
		mul_req.b = {47'b0, 17'(17'h10000 - {1'b0, learn_rate_q})};
		h_we = 1'b0;
		h_wa = pos_q[HA-1:0];
		h_wd = shifted[7:0];
		h_ra = cand_back[HA-1:0];
		h_rb = pos_back[HA-1:0];
		b_we = 1'b0;
		b_wa = key_q[BA-1:0];
		b_wd = {new_vld, key_q, new_pos};

		unique case (state_q)
			ST_CLR: begin
				b_we = 1'b1;
				b_wa = clr_idx_q;
				b_wd = '0;
			end
			ST_ADP: mul_req.start = 1'b1;
			ST_SHIFT: h_we = completes;
			ST_HASH: begin
				mul_req.start = 1'b1;
				mul_req.a = h_q ^ {56'b0, win_q[k_q]};
				mul_req.b = FNV_PRIME;
			end
			ST_MIX: begin
				mul_req.start = 1'b1;
				mul_req.a = h_q ^ (h_q >> 33);
				mul_req.b = MIX_MUL;
			end
			ST_NRD: h_ra = cand_next[HA-1:0];
			ST_BWR: b_we = 1'b1;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			learn_rate_q <= LEARN_RATE_RST;
			conf_floor_q <= CONF_FLOOR_RST;
			conf_ceiling_q <= CONF_CEIL_RST;
			partial_q <= 9'd1;
			pos_q <= '0;
			exp_q <= '0;
			conf_state_q <= '0;
			active_q <= 1'b0;
			for (int i = 0; i < CONF_STATES; i++) begin
				conf_tbl_q[i] <= CONF_INIT;
			end
			clr_idx_q <= '0;
			k_q <= '0;
			wi_q <= '0;
			used_q <= '0;
			si_q <= '0;
			out_valid_q <= 1'b0;
			tie_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cfg_idx_t'(cfg.index))
					CFG_LEARN_RATE:   learn_rate_q <= cfg.data;
					CFG_CONF_FLOOR:   conf_floor_q <= cfg.data;
					CFG_CONF_CEILING: conf_ceiling_q <= cfg.data;
					default: ;
				endcase
			end
			// A new result replaces the one being taken in the same cycle.
			if ((state_q == ST_PRED) && (!out_valid_q || results.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: clr_idx_q <= clr_idx_q + BA'(1);
				ST_ADP_W: if (mul_rsp.done) conf_tbl_q[conf_state_q] <= nc_sat;
				ST_SHIFT: begin
					if (completes) begin
						partial_q <= 9'd1;
						active_q <= 1'b0;
						k_q <= 3'd7;
					end else begin
						partial_q <= shifted;
					end
				end
				ST_HASH_W: if (mul_rsp.done) k_q <= k_q - 3'd1;
				ST_BCHK: begin
					match_q <= key_eq;
					wi_q <= '0;
					used_q <= '0;
				end
				ST_WAY: begin
					if (wi_q == WAYS) begin
						si_q <= '0;
						tie_q <= 1'b0;
					end else if (!elig) begin
						wi_q <= wi_q + WI'(1);
					end
				end
				ST_MCMP: if ((h_rda != h_rdb) && (j_q < MIN_MATCH)) wi_q <= wi_q + WI'(1);
				ST_VOTE: begin
					wi_q <= wi_q + WI'(1);
					if (!hit_any) used_q <= used_q + WI'(1);
				end
				ST_SEL: begin
					if (si_q != used_q) begin
						si_q <= si_q + WI'(1);
						if ((si_q == '0) || (sel_score > best_score_q)) tie_q <= 1'b0;
						else if (sel_score == best_score_q) tie_q <= 1'b1;
					end
				end
				ST_DEC: begin
					if ((used_q != '0) && !tie_q) begin
						exp_q <= best_val_q;
						conf_state_q <= {lb, vb};
						active_q <= 1'b1;
					end
				end
				ST_PINC: pos_q <= pos_q + 32'd1;
				default: ;
			endcase
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (accept) bit_q <= bits.coded_bit;
			ST_SHIFT: begin
				done_q <= completes;
				if (completes) begin
					win_q[0] <= shifted[7:0];
					for (int i = 1; i < 8; i++) begin
						win_q[i] <= win_q[i-1];
					end
					h_q <= FNV_OFFSET;
				end
			end
			ST_HASH_W: if (mul_rsp.done) h_q <= mul_rsp.prod;
			ST_MIX_W: if (mul_rsp.done) key_q <= (mul_rsp.prod ^ (mul_rsp.prod >> 33)) | 64'd1;
			ST_BCHK: row_q <= b_rd;
			ST_WAY: if ((wi_q != WAYS) && elig) begin
				cand_q <= way_cand;
				j_q <= '0;
			end
			ST_NWT: nxt_q <= h_rda;
			ST_MCMP: if (h_rda == h_rdb) j_q <= j_q + JW'(1);
			ST_VOTE: begin
				if (hit_any) begin
					score_q[hit_idx] <= score_q[hit_idx] + SW'(j_q);
					votes_q[hit_idx] <= votes_q[hit_idx] + VW'(1);
				end else begin
					val_q[used_q[IW-1:0]] <= nxt_q;
					score_q[used_q[IW-1:0]] <= SW'(j_q);
					votes_q[used_q[IW-1:0]] <= VW'(1);
				end
			end
			ST_SEL: begin
				if ((si_q != used_q) && ((si_q == '0) || (sel_score > best_score_q))) begin
					best_val_q <= val_q[si_q[IW-1:0]];
					best_score_q <= sel_score;
					best_votes_q <= votes_q[si_q[IW-1:0]];
				end
			end
			ST_PRED: begin
				if (!out_valid_q || results.ready) begin
					prob_q <= prob_next;
					ctx_q <= ctx_next;
					bdone_q <= done_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[rtl/hmvp_checker.sv]
`default_nettype none
module hmvp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        bits_valid,
	input logic        bits_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] prob_one,
	input logic [5:0]  mixer_ctx,
	input logic        byte_done,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// A waiting result holds still until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(prob_one) && $stable(mixer_ctx)
			&& $stable(byte_done))
		else $error("result changed while stalled");

	// Each bit is worked on alone, so the block is busy right after taking one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		bits_valid && bits_ready |=> !bits_ready)
		else $error("bit taken while previous bit still in work");

	// With no prediction the probability is exactly one half.
	a_idle_half: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (mixer_ctx == 6'd0) |-> prob_one == 16'd32768)
		else $error("inactive result with biased probability");

	a_ctx_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> mixer_ctx <= 6'd32)
		else $error("mixer context out of range");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind hashed_match_vote_predictor_core hmvp_checker u_hmvp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.bits_valid (bits.valid),
	.bits_ready (bits.ready),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.prob_one   (results.prob_one),
	.mixer_ctx  (results.mixer_ctx),
	.byte_done  (results.byte_done),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready)
);
`default_nettype wire
